>>> rtl/core/sef_pkg.sv
// sef_pkg: shared widths and register indexes of the STX/ETX frame receiver.
// No dependencies; imported by the interfaces and the top level.
package sef_pkg;

    localparam int BYTE_W    = 8;   // received and payload byte
    localparam int INDEX_W   = 5;   // byte_index field
    localparam int FLEN_W    = 6;   // frame_length field
    localparam int CFG_IDX_W = 1;   // configuration register index

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_START_BYTE = 1'd0;
    localparam cfg_idx_t REG_END_BYTE   = 1'd1;

    localparam byte_t START_BYTE_RST = 8'h02;
    localparam byte_t END_BYTE_RST   = 8'h03;

endpackage

>>> rtl/core/sef_ifs.sv
// sef_ifs: valid/ready channel interfaces of the frame receiver
// (input byte, result item, configuration write). Depends on sef_pkg.

interface sef_rx_if
    import sef_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sef_out_if
    import sef_pkg::*;
();
    logic               valid;
    logic               ready;
    byte_t              payload_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [FLEN_W-1:0]  frame_length;
    logic               last;

    modport source (output valid, output payload_byte, output byte_index,
                    output frame_length, output last, input ready);
    modport sink   (input valid, input payload_byte, input byte_index,
                    input frame_length, input last, output ready);
endinterface

interface sef_cfg_if
    import sef_pkg::*;
();
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    byte_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/sef_ram.sv
// sef_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module sef_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/stx_etx_frame_receiver.sv
// stx_etx_frame_receiver: STX/len/payload/XOR/ETX frame parser with replay.
// Parsing: one byte item accepted per cycle; input is held off during replay.
// After a good ETX the payload is replayed from the payload RAM: a registered
// RAM read first, then one result per cycle while the output register is free;
// an empty frame gives a zero result. Reset (async, rst_n low) clears the
// parser to idle and loads start/end bytes 2 and 3; RAM contents are not reset.
// Depends on sef_pkg, sef_ifs, sef_ram.
module stx_etx_frame_receiver
    import sef_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    sef_rx_if.sink   in_ch,
    sef_out_if.source out_ch,
    sef_cfg_if.sink  cfg_ch
);

    // count holds 0..MAX_PAYLOAD, address holds 0..MAX_PAYLOAD-1
    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    // parser states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LEN  = 3'd1;
    localparam logic [2:0] ST_DATA = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_END  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;   // replaying payload from RAM

    logic [2:0]       state_reg,   state_next;
    byte_t            start_reg,   start_next;
    byte_t            end_reg,     end_next;
    logic [CNT_W-1:0] exp_len_reg, exp_len_next;
    logic [CNT_W-1:0] rcv_cnt_reg, rcv_cnt_next;
    byte_t            xor_reg,     xor_next;
    logic [CNT_W-1:0] emit_idx_reg, emit_idx_next;
    logic             data_ok_reg, data_ok_next;   // RAM data matches emit_idx
    logic             out_valid_reg, out_valid_next;

    // result payload, no reset needed
    byte_t              out_byte_reg,  out_byte_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic [FLEN_W-1:0]  out_flen_reg,  out_flen_next;
    logic               out_last_reg,  out_last_next;

    byte_t            b;
    logic             in_fire;
    logic             slot_free;
    logic             emit_go;
    logic             emit_last;
    logic [CNT_W-1:0] cnt_inc;
    logic             ram_wr_en;
    logic [AW-1:0]    ram_rd_addr;
    byte_t            ram_rd_data;

    assign b         = in_ch.rx_byte;
    assign in_ch.ready = (state_reg != ST_EMIT);
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;

    // output register frees when empty or being taken
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign emit_go   = (state_reg == ST_EMIT) && slot_free
                       && (data_ok_reg || (exp_len_reg == '0));
    assign emit_last = (exp_len_reg == '0) || (emit_idx_reg + 1'b1 == exp_len_reg);
    assign cnt_inc   = rcv_cnt_reg + 1'b1;

    // payload write while collecting data bytes
    assign ram_wr_en = in_fire && (state_reg == ST_DATA) && (b != start_reg);
    // read ahead: address follows the index that will be current next cycle
    assign ram_rd_addr = emit_go ? AW'(emit_idx_reg + 1'b1) : AW'(emit_idx_reg);

    sef_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PAYLOAD)
    ) u_payload_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (rcv_cnt_reg[AW-1:0]),
        .wr_data (b),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        exp_len_next   = exp_len_reg;
        rcv_cnt_next   = rcv_cnt_reg;
        xor_next       = xor_reg;
        emit_idx_next  = emit_idx_reg;
        data_ok_next   = data_ok_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_index_next = out_index_reg;
        out_flen_next  = out_flen_reg;
        out_last_next  = out_last_reg;

        // config writes must arrive only while idle; the block leaves this to the user
        if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                REG_START_BYTE: start_next = cfg_ch.data;
                REG_END_BYTE:   end_next   = cfg_ch.data;
                default:        ;
            endcase
        end

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (state_reg == ST_EMIT)
        begin
            data_ok_next = 1'b1;
            if (emit_go)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = (exp_len_reg == '0) ? '0 : ram_rd_data;
                out_index_next = INDEX_W'(emit_idx_reg);
                out_flen_next  = FLEN_W'(exp_len_reg);
                out_last_next  = emit_last;
                emit_idx_next  = emit_idx_reg + 1'b1;
                if (emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
        end
        else if (in_fire)
        begin
            unique case (state_reg)
                ST_LEN:
                begin
                    if (b > BYTE_W'(MAX_PAYLOAD))
                    begin
                        exp_len_next = '0;
                        rcv_cnt_next = '0;
                        xor_next     = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        exp_len_next = CNT_W'(b);
                        state_next   = (b == '0) ? ST_CHK : ST_DATA;
                    end
                end
                ST_DATA:
                begin
                    if (b == start_reg)
                    begin
                        // restart: next byte is a length
                        exp_len_next = '0;
                        rcv_cnt_next = '0;
                        xor_next     = '0;
                        state_next   = ST_LEN;
                    end
                    else
                    begin
                        xor_next     = xor_reg ^ b;
                        rcv_cnt_next = cnt_inc;
                        if (cnt_inc >= exp_len_reg)
                        begin
                            state_next = ST_CHK;
                        end
                    end
                end
                ST_CHK:
                begin
                    if (b == start_reg)
                    begin
                        exp_len_next = '0;
                        rcv_cnt_next = '0;
                        xor_next     = '0;
                        state_next   = ST_LEN;
                    end
                    else if (b == xor_reg)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        exp_len_next = '0;
                        rcv_cnt_next = '0;
                        xor_next     = '0;
                        state_next   = ST_IDLE;
                    end
                end
                ST_END:
                begin
                    if (b == end_reg)
                    begin
                        // good frame: replay, frame counters kept as they are
                        emit_idx_next = '0;
                        data_ok_next  = 1'b0;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        // wrong end byte, start byte here is lost too
                        exp_len_next = '0;
                        rcv_cnt_next = '0;
                        xor_next     = '0;
                        state_next   = ST_IDLE;
                    end
                end
                default:
                begin
                    // idle and unused codes
                    if (b == start_reg)
                    begin
                        rcv_cnt_next = '0;
                        xor_next     = '0;
                        state_next   = ST_LEN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= START_BYTE_RST;
            end_reg       <= END_BYTE_RST;
            exp_len_reg   <= '0;
            rcv_cnt_reg   <= '0;
            xor_reg       <= '0;
            emit_idx_reg  <= '0;
            data_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            exp_len_reg   <= exp_len_next;
            rcv_cnt_reg   <= rcv_cnt_next;
            xor_reg       <= xor_next;
            emit_idx_reg  <= emit_idx_next;
            data_ok_reg   <= data_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_index_reg <= out_index_next;
        out_flen_reg  <= out_flen_next;
        out_last_reg  <= out_last_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.payload_byte = out_byte_reg;
    assign out_ch.byte_index   = out_index_reg;
    assign out_ch.frame_length = out_flen_reg;
    assign out_ch.last         = out_last_reg;

endmodule

>>> bench/sef_frame_checker.sv
// sef_frame_checker: watches the byte, result and register channels of the frame
// receiver, predicts every replayed payload item and compares it field by field.
// Depends on sef_pkg and sef_ifs.
module sef_frame_checker
    import sef_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    sef_rx_if           in_ch,
    sef_out_if          out_ch,
    sef_cfg_if          cfg_ch,
    output int unsigned fail_count,
    output int unsigned pending
);

    typedef enum logic [2:0] {PS_IDLE, PS_LEN, PS_DATA, PS_CHK, PS_END} parse_state_e;

    typedef struct packed {
        byte_t              payload_byte;
        logic [INDEX_W-1:0] byte_index;
        logic [FLEN_W-1:0]  frame_length;
        logic               last;
    } replay_item_t;

    byte_t         start_val;
    byte_t         end_val;
    parse_state_e  pstate;
    byte_t         payload_mem [MAX_PAYLOAD];
    int            exp_len;
    int            rcvd_count;
    byte_t         run_xor;
    replay_item_t  replay_due [$];
    int unsigned   mismatches;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic clear_frame();
        exp_len    = 0;
        rcvd_count = 0;
        run_xor    = '0;
    endtask

    // one received byte through the parser; a good end byte queues the replay
    task automatic parse_byte(input byte_t b);
        replay_item_t ri;
        int           len;
        case (pstate)
            PS_LEN:
                if (b > MAX_PAYLOAD) begin
                    clear_frame();
                    pstate = PS_IDLE;
                end
                else begin
                    exp_len = b;
                    pstate  = (b == 0) ? PS_CHK : PS_DATA;
                end
            PS_DATA:
                if (b == start_val) begin
                    clear_frame();
                    pstate = PS_LEN;
                end
                else begin
                    if (rcvd_count < MAX_PAYLOAD)
                        payload_mem[rcvd_count] = b;
                    run_xor ^= b;
                    rcvd_count++;
                    if (rcvd_count >= exp_len)
                        pstate = PS_CHK;
                end
            PS_CHK:
                if (b == start_val) begin
                    clear_frame();
                    pstate = PS_LEN;
                end
                else if (b == run_xor) begin
                    pstate = PS_END;
                end
                else begin
                    clear_frame();
                    pstate = PS_IDLE;
                end
            PS_END:
                if (b == end_val) begin
                    len = (exp_len > MAX_PAYLOAD) ? MAX_PAYLOAD : exp_len;
                    if (len == 0) begin
                        ri = '{payload_byte: '0, byte_index: '0, frame_length: '0, last: 1'b1};
                        replay_due.push_back(ri);
                    end
                    for (int k = 0; k < len; k++) begin
                        ri.payload_byte = payload_mem[k];
                        ri.byte_index   = k[INDEX_W-1:0];
                        ri.frame_length = len[FLEN_W-1:0];
                        ri.last         = (k + 1 == len);
                        replay_due.push_back(ri);
                    end
                    pstate = PS_IDLE;
                end
                else begin
                    clear_frame();
                    pstate = PS_IDLE;
                end
            default:
                if (b == start_val) begin
                    rcvd_count = 0;
                    run_xor    = '0;
                    pstate     = PS_LEN;
                end
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        replay_item_t want;
        if (!rst_n) begin
            start_val  = START_BYTE_RST;
            end_val    = END_BYTE_RST;
            pstate     = PS_IDLE;
            mismatches = 0;
            clear_frame();
            replay_due.delete();
        end
        else begin
            // results first: nothing accepted at this edge can already be due
            if (out_ch.valid && out_ch.ready) begin
                if (replay_due.size() == 0) begin
                    report_mismatch("unexpected item, payload_byte", out_ch.payload_byte, -1);
                end
                else begin
                    want = replay_due.pop_front();
                    if (out_ch.payload_byte !== want.payload_byte)
                        report_mismatch("payload_byte", out_ch.payload_byte, want.payload_byte);
                    if (out_ch.byte_index !== want.byte_index)
                        report_mismatch("byte_index", out_ch.byte_index, want.byte_index);
                    if (out_ch.frame_length !== want.frame_length)
                        report_mismatch("frame_length", out_ch.frame_length, want.frame_length);
                    if (out_ch.last !== want.last)
                        report_mismatch("last", out_ch.last, want.last);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == REG_START_BYTE)
                    start_val = cfg_ch.data;
                else if (cfg_ch.index == REG_END_BYTE)
                    end_val = cfg_ch.data;
            end
            if (in_ch.valid && in_ch.ready)
                parse_byte(in_ch.rx_byte);
        end
        pending    <= replay_due.size();
        fail_count <= mismatches;
    end

endmodule

>>> bench/stx_etx_frame_receiver_tb.sv
// stx_etx_frame_receiver_tb: drives framed byte streams into the receiver under
// several start/end byte settings and gives the verdict; checking is done by
// sef_frame_checker. Depends on sef_pkg, sef_ifs, the receiver and the checker.
module stx_etx_frame_receiver_tb;
    import sef_pkg::*;

    localparam int MAX_PAYLOAD = 32;
    localparam int STALL_LIMIT = 2000;  // cycles with no item moved on any channel
    localparam int LONG_HOLD   = 300;   // result side held off this long once
    localparam int PHASE_ITEMS = 48;    // random bytes per register setting, roughly
    localparam int NUM_PHASES  = 4;

    // shapes of generated frames
    typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_END, FR_CUT, FR_NOISE} frame_kind_e;

    logic clk;
    logic rst_n;

    sef_rx_if  in_ch ();
    sef_out_if out_ch ();
    sef_cfg_if cfg_ch ();

    int unsigned fail_count;
    int unsigned pending;
    int unsigned hold_requests;  // bumped to ask the result side for one long hold

    byte_t frame_q [$];  // bytes of the phase being sent
    byte_t start_val;    // start/end bytes in effect, used only to shape frames
    byte_t end_val;

    stx_etx_frame_receiver #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    sef_frame_checker #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) frame_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_ch     (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Append one frame to frame_q. Payload bytes avoid the start byte, and the
    // payload is redrawn a few times if its XOR lands on the start byte, since
    // the parser would take such a checksum as a restart.
    task automatic push_frame(input int len, input frame_kind_e kind);
        byte_t body [$];
        byte_t sum;
        byte_t b;
        int    tries;
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 4))
                frame_q.push_back(byte_t'($urandom_range(0, 255)));
            return;
        end
        tries = 0;
        do begin
            body.delete();
            sum = '0;
            for (int i = 0; i < len; i++) begin
                do b = byte_t'($urandom_range(0, 255)); while (b == start_val);
                body.push_back(b);
                sum ^= b;
            end
            tries++;
        end while (sum == start_val && tries < 8);
        frame_q.push_back(start_val);
        frame_q.push_back(byte_t'(len));
        if (kind == FR_CUT) begin
            // broken off partway; later bytes but a start byte land in the payload
            for (int i = 0; i < len / 2; i++)
                frame_q.push_back(body[i]);
            return;
        end
        foreach (body[j])
            frame_q.push_back(body[j]);
        if (kind == FR_BAD_SUM)
            frame_q.push_back(sum ^ byte_t'(1 << $urandom_range(0, 7)));
        else
            frame_q.push_back(sum);
        if (kind == FR_BAD_END)
            frame_q.push_back(end_val ^ byte_t'($urandom_range(1, 255)));
        else
            frame_q.push_back(end_val);
    endtask

    // Send frame_q in bursts of random length with random gaps. valid stays up
    // across back-to-back items and is only dropped for a real gap.
    task automatic send_bytes();
        int k;
        int burst;
        int gap;
        k = 0;
        while (k < frame_q.size()) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40)
                                                : $urandom_range(1, 8);
            in_ch.valid <= 1'b1;
            while (burst > 0 && k < frame_q.size()) begin
                in_ch.rx_byte <= frame_q[k];
                do @(posedge clk); while (!in_ch.ready);
                k++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    // Wait for the replay queue to drain, then a few cycles for bytes that
    // produce nothing. The first edge lets the checker count the last byte.
    task automatic settle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Result side: the stall pattern is redrawn when a random countdown runs out;
    // one long hold on request so the replay backs up and the byte input stalls.
    initial begin
        int unsigned holds_done;
        int          mode;
        int          tick;
        holds_done = 0;
        mode       = 0;
        tick       = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_requests != holds_done) begin
                holds_done = hold_requests;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if (tick == 0) begin
                mode = $urandom_range(0, 3);
                tick = $urandom_range(20, 80);
            end
            tick--;
            case (mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= 1'($urandom_range(0, 1));
                2:       out_ch.ready <= ((tick % 4) == 0);
                default: out_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Watchdog: too long with nothing moving on any channel ends the run.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("stx_etx_frame_receiver_tb NOT OK");
        $finish;
    end

    initial begin
        int          r;
        int          len;
        byte_t       s;
        byte_t       e;
        frame_kind_e kind;

        in_ch.valid   <= 1'b0;
        in_ch.rx_byte <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= REG_START_BYTE;
        cfg_ch.data   <= '0;
        hold_requests <= 0;
        rst_n         <= 1'b0;
        start_val = START_BYTE_RST;
        end_val   = END_BYTE_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, with the reset start/end bytes:
        //   empty frame; length too big; length equal to the start byte, then a
        //   start byte in the payload; start byte in the checksum place; good
        //   checksum but start byte in place of the end byte (frame lost);
        //   checksum mismatch; one-byte frame of all ones.
        frame_q = {START_BYTE_RST, 8'h00, 8'h00, END_BYTE_RST,
                   START_BYTE_RST, 8'h21,
                   START_BYTE_RST, START_BYTE_RST, 8'hFF, START_BYTE_RST,
                   8'h01, 8'h00, START_BYTE_RST,
                   8'h01, 8'h80, 8'h80, START_BYTE_RST,
                   START_BYTE_RST, 8'h01, 8'h7F, 8'h00,
                   START_BYTE_RST, 8'h01, 8'hFF, 8'hFF, END_BYTE_RST};
        send_bytes();
        settle();

        // Random phases: zero/all-ones extremes both ways, equal start and end
        // bytes, then a random pair. Each phase opens with a full-size frame.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       begin s = 8'h00; e = 8'hFF; end
                1:       begin s = 8'hFF; e = 8'h00; end
                2:       begin s = 8'h7E; e = 8'h7E; end
                default: begin
                    s = byte_t'($urandom_range(0, 255));
                    e = byte_t'($urandom_range(0, 255));
                end
            endcase

            // both registers in one go, valid held high between them
            cfg_ch.valid <= 1'b1;
            for (int reg_n = 0; reg_n < 2; reg_n++) begin
                cfg_ch.index <= (reg_n == 0) ? REG_START_BYTE : REG_END_BYTE;
                cfg_ch.data  <= (reg_n == 0) ? s : e;
                do @(posedge clk); while (!cfg_ch.ready);
            end
            cfg_ch.valid <= 1'b0;
            start_val = s;
            end_val   = e;

            if (ph == 1)
                hold_requests <= hold_requests + 1;

            frame_q.delete();
            push_frame(MAX_PAYLOAD, FR_GOOD);
            while (frame_q.size() < PHASE_ITEMS) begin
                // mostly short frames, now and then any length up to the maximum
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PAYLOAD)
                                                  : $urandom_range(0, 6);
                r = $urandom_range(0, 11);
                kind = (r < 8)   ? FR_GOOD    :
                       (r == 8)  ? FR_BAD_SUM :
                       (r == 9)  ? FR_BAD_END :
                       (r == 10) ? FR_CUT     : FR_NOISE;
                push_frame(len, kind);
            end
            send_bytes();
            settle();
        end

        if (fail_count == 0)
            $display("stx_etx_frame_receiver_tb OK");
        else
            $display("stx_etx_frame_receiver_tb NOT OK");
        $finish;
    end

endmodule

>>> stx_etx_frame_receiver.f
rtl/core/sef_pkg.sv
rtl/core/sef_ifs.sv
rtl/core/sef_ram.sv
rtl/core/stx_etx_frame_receiver.sv
bench/sef_frame_checker.sv
bench/stx_etx_frame_receiver_tb.sv
